// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// The clock is clk and the active-low reset is rst_n in every user.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define SMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A signal holds its value while its beat is stalled.
`define SMM_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  `SMM_ASSERT(lbl, (vld) && !(rdy) |=> $stable(sig), msg)

`endif

// File: rtl/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Types and constants shared by the square matrix multiplier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  // Default matrix dimension.
  localparam int MATRIX_DIM_DEF = 16;

  // Fixed field widths.
  localparam int ELEM_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 36;
  localparam int IDX_W  = 4;

  // Command codes.
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Matrix select codes for writes.
  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  // Input beat.
  typedef struct packed {
    logic                     command;
    logic                     matrix_select;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic signed [ACC_W-1:0] product_value;
    logic [IDX_W-1:0]        product_col;
    logic                    last_in_row;
  } out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;
    logic start;
    logic issue;
    logic shift;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wr_ok;
    logic row_ok;
    logic k_last;
    logic col_last;
    logic pipe_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/square_matrix_multiply.sv
// A write beat stores one signed Q1.15 element of A or B. A compute beat for
// row r reads one element of row r of A and the whole row of B each cycle,
// feeding MATRIX_DIM parallel multiply-accumulate lanes; the single read port
// of the A store sets that pace, and the read and multiply registers lie ahead
// of the accumulators. The MATRIX_DIM results then leave one per beat in
// column order, with 30 fraction bits and the last one flagged. Input is taken
// only while no row is in progress. Out-of-range writes and computes are
// dropped without a result.
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Fixed-point square matrix multiplier, C = A x B, one result row per
// compute beat.
// ----------------------------------------------------------------------------
`default_nettype none

module square_matrix_multiply #(
  parameter int MATRIX_DIM = smm_pkg::MATRIX_DIM_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire smm_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output smm_pkg::out_t      out_data
);

  smm_pkg::ctrl_cmd_t  cmd;
  smm_pkg::dp_status_t status;

  // Controller.
  smm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath.
  smm_dp #(
    .MATRIX_DIM (MATRIX_DIM)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/smm_ctrl.sv
// ----------------------------------------------------------------------------
// smm_ctrl
// Controller for the matrix multiplier: sequences element writes, the
// row of multiply-accumulate steps, the pipeline drain and the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_command,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire smm_pkg::dp_status_t status,
  output smm_pkg::ctrl_cmd_t      cmd
);

  smm_pkg::state_t state_r;
  smm_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smm_pkg::ST_IDLE: begin
        if (in_valid && in_command == smm_pkg::CMD_COMPUTE && status.row_ok) begin
          state_nxt = smm_pkg::ST_RUN;
        end
      end
      smm_pkg::ST_RUN: begin
        if (status.k_last) begin
          state_nxt = smm_pkg::ST_DRAIN;
        end
      end
      smm_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = smm_pkg::ST_EMIT;
        end
      end
      smm_pkg::ST_EMIT: begin
        if (out_ready && status.col_last) begin
          state_nxt = smm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smm_pkg::ST_IDLE;
      end
    endcase
  end

  // Output logic: handshakes and datapath commands.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      smm_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.wr_en = in_valid && in_command == smm_pkg::CMD_WRITE && status.wr_ok;
        cmd.start = in_valid && in_command == smm_pkg::CMD_COMPUTE && status.row_ok;
      end
      smm_pkg::ST_RUN: begin
        cmd.issue = 1'b1;
      end
      smm_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.shift = out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/smm_dp.sv
// ----------------------------------------------------------------------------
// smm_dp
// Datapath for the matrix multiplier: the two element stores, one lane of
// multiply-accumulate per result column, and the result shift line.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_dp #(
  parameter int MATRIX_DIM = smm_pkg::MATRIX_DIM_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire smm_pkg::in_t        in_data,
  input  wire smm_pkg::ctrl_cmd_t  cmd,
  output smm_pkg::dp_status_t      status,
  output smm_pkg::out_t            out_data
);

  localparam int IW = $clog2(MATRIX_DIM);
  localparam int AW = $clog2(MATRIX_DIM * MATRIX_DIM);
  localparam logic [AW-1:0] DIM_A    = AW'(MATRIX_DIM);
  localparam logic [IW-1:0] IDX_LAST = IW'(MATRIX_DIM - 1);

  logic [IW-1:0] row_r;
  logic [IW-1:0] k_r;
  logic [IW-1:0] col_r;
  logic          rd_vld_r;
  logic          mul_vld_r;

  logic [IW-1:0] wr_row;
  logic [IW-1:0] wr_col;
  logic [AW-1:0] a_waddr;
  logic [AW-1:0] a_raddr;

  logic [smm_pkg::ELEM_W-1:0]        a_mem [MATRIX_DIM*MATRIX_DIM];
  logic signed [smm_pkg::ELEM_W-1:0] a_rd_r;
  logic signed [smm_pkg::ELEM_W-1:0] b_rd [MATRIX_DIM];
  logic signed [smm_pkg::PROD_W-1:0] mul_r [MATRIX_DIM];
  logic signed [smm_pkg::ACC_W-1:0]  acc_r [MATRIX_DIM];

  // Range checks on the incoming beat, and the counter and pipeline status.
  always_comb begin
    status.wr_ok     = (int'(in_data.row_index) < MATRIX_DIM) &&
                       (int'(in_data.col_index) < MATRIX_DIM);
    status.row_ok    = int'(in_data.row_index) < MATRIX_DIM;
    status.k_last    = k_r == IDX_LAST;
    status.col_last  = col_r == IDX_LAST;
    status.pipe_busy = rd_vld_r || mul_vld_r;
  end

  // Store addresses, row-major for the left matrix.
  assign wr_row  = IW'(in_data.row_index);
  assign wr_col  = IW'(in_data.col_index);
  assign a_waddr = AW'(wr_row) * DIM_A + AW'(wr_col);
  assign a_raddr = AW'(row_r) * DIM_A + AW'(k_r);

  // Left matrix store: one element per cycle along the selected row.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_data.matrix_select == smm_pkg::SEL_LEFT) begin
      a_mem[a_waddr] <= in_data.element_value;
    end
    if (cmd.issue) begin
      a_rd_r <= a_mem[a_raddr];
    end
  end

  // Right matrix store, one column memory per lane, all read at row k.
  for (genvar gc = 0; gc < MATRIX_DIM; gc++) begin : g_bcol
    logic [smm_pkg::ELEM_W-1:0]        b_mem [MATRIX_DIM];
    logic signed [smm_pkg::ELEM_W-1:0] b_rd_r;

    always_ff @(posedge clk) begin
      if (cmd.wr_en && in_data.matrix_select == smm_pkg::SEL_RIGHT &&
          wr_col == IW'(gc)) begin
        b_mem[wr_row] <= in_data.element_value;
      end
      if (cmd.issue) begin
        b_rd_r <= b_mem[k_r];
      end
    end

    assign b_rd[gc] = b_rd_r;
  end

  // Sequencing counters and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      col_r     <= '0;
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.issue;
      mul_vld_r <= rd_vld_r;
      if (cmd.start) begin
        k_r   <= '0;
        col_r <= '0;
      end else begin
        if (cmd.issue) begin
          k_r <= k_r + IW'(1);
        end
        if (cmd.shift) begin
          col_r <= col_r + IW'(1);
        end
      end
    end
  end

  // Requested row.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r <= wr_row;
    end
  end

  // Lane multipliers, registered before accumulation.
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      for (int c = 0; c < MATRIX_DIM; c++) begin
        mul_r[c] <= a_rd_r * b_rd[c];
      end
    end
  end

  // Accumulators; after the row is done they shift out toward lane zero.
  always_ff @(posedge clk) begin
    for (int c = 0; c < MATRIX_DIM; c++) begin
      if (cmd.start) begin
        acc_r[c] <= '0;
      end else if (mul_vld_r) begin
        acc_r[c] <= acc_r[c] + smm_pkg::ACC_W'(mul_r[c]);
      end
    end
    if (cmd.shift) begin
      for (int c = 0; c < MATRIX_DIM - 1; c++) begin
        acc_r[c] <= acc_r[c + 1];
      end
    end
  end

  // Result beat.
  always_comb begin
    out_data.product_value = acc_r[0];
    out_data.product_col   = smm_pkg::IDX_W'(col_r);
    out_data.last_in_row   = col_r == IDX_LAST;
  end

endmodule

`default_nettype wire

// File: rtl/smm_checker.sv
// ----------------------------------------------------------------------------
// smm_checker
// Port-level checks on the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module smm_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire smm_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire smm_pkg::out_t out_data
);

  logic                      mid_row;
  logic [smm_pkg::IDX_W-1:0] col_next;

  // A result beat that is taken and is not the last of its row.
  assign mid_row  = out_valid && out_ready && !out_data.last_in_row;
  assign col_next = out_data.product_col + smm_pkg::IDX_W'(1);

  // A stalled input beat keeps its payload.
  `SMM_ASSERT_HOLD(a_in_hold, in_valid, in_ready, in_data, "stalled input beat changed")

  // A stalled result beat keeps its payload.
  `SMM_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_data, "stalled result beat changed")

  // No input is taken while a result row is being delivered.
  `SMM_ASSERT(a_one_side, !(in_ready && out_valid), "input ready during result row")

  // A row keeps going until its last beat.
  `SMM_ASSERT(a_row_continues, mid_row |=> out_valid, "result row ended early")

  // Columns step by one within a row.
  `SMM_ASSERT(a_col_step, mid_row |=> out_data.product_col == $past(col_next), "column skipped")

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the square matrix multiplier. All of B and a few
// rows of A are loaded before the first row is computed, and computes only
// name those rows. Then a short list of fixed rows runs, followed by random
// element writes and row computes under four mixes of sender idling and
// receiver stalls. Every result beat is checked against a fixed-point dot
// product computed in the bench.
// ----------------------------------------------------------------------------

module tb;

  localparam int DIM            = smm_pkg::MATRIX_DIM_DEF;
  localparam int ELEM_W         = smm_pkg::ELEM_W;
  localparam int IDX_W          = smm_pkg::IDX_W;
  localparam int ACC_W          = smm_pkg::ACC_W;
  localparam int BEATS_PER_MIX  = 8;
  localparam int ROW_LATENCY    = 2 * DIM + 4;
  localparam int CYCLE_LIMIT    = 500000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  smm_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  smm_pkg::out_t out_data;

  // Bench copy of both matrices.
  logic signed [ELEM_W-1:0] left_mat [DIM][DIM];
  logic signed [ELEM_W-1:0] right_mat [DIM][DIM];

  smm_pkg::in_t  pending_beats_q[$];
  smm_pkg::out_t expected_products_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int write_count = 0;
  int row_count = 0;
  int product_count = 0;
  int cycle_count = 0;

  square_matrix_multiply #(.MATRIX_DIM(DIM)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock and the single reset at the start.
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Update the stored matrices on a write, or work out a whole row of C.
  function automatic void apply_matrix_beat(smm_pkg::in_t beat);
    longint        acc;
    smm_pkg::out_t prod;
    if (beat.command == smm_pkg::CMD_WRITE) begin
      write_count++;
      if (beat.row_index < DIM && beat.col_index < DIM) begin
        if (beat.matrix_select == smm_pkg::SEL_LEFT) begin
          left_mat[beat.row_index][beat.col_index] = beat.element_value;
        end else begin
          right_mat[beat.row_index][beat.col_index] = beat.element_value;
        end
      end
    end else begin
      row_count++;
      if (beat.row_index < DIM) begin
        for (int c = 0; c < DIM; c++) begin
          acc = 0;
          for (int k = 0; k < DIM; k++) begin
            acc += longint'(left_mat[beat.row_index][k]) * longint'(right_mat[k][c]);
          end
          prod.product_value = acc[ACC_W-1:0];
          prod.product_col   = c[IDX_W-1:0];
          prod.last_in_row   = (c == DIM - 1);
          expected_products_q.push_back(prod);
        end
      end
    end
  endfunction

  // Compare one result beat against the oldest expected product.
  function automatic void check_product_beat(smm_pkg::out_t got);
    smm_pkg::out_t want;
    if (expected_products_q.size() == 0) begin
      $display("%0t: unexpected result beat: value %0d col %0d last %0b", $time,
               got.product_value, got.product_col, got.last_in_row);
      error_count++;
    end else begin
      want = expected_products_q.pop_front();
      product_count++;
      if (got.product_value !== want.product_value) begin
        $display("%0t: product_value mismatch: expected %0d, actual %0d", $time,
                 want.product_value, got.product_value);
        error_count++;
      end
      if (got.product_col !== want.product_col) begin
        $display("%0t: product_col mismatch: expected %0d, actual %0d", $time,
                 want.product_col, got.product_col);
        error_count++;
      end
      if (got.last_in_row !== want.last_in_row) begin
        $display("%0t: last_in_row mismatch: expected %0b, actual %0b", $time,
                 want.last_in_row, got.last_in_row);
        error_count++;
      end
    end
  endfunction

  // Element values lean toward the ends of the Q1.15 range and the values around zero.
  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // One of the rows of A that is loaded in full.
  function automatic int pick_loaded_row();
    case ($urandom_range(3))
      0: return 0;
      1: return 1;
      2: return 2;
      default: return DIM - 1;
    endcase
  endfunction

  function automatic smm_pkg::in_t write_beat(logic sel, int row, int col,
                                              logic signed [ELEM_W-1:0] value);
    smm_pkg::in_t beat;
    beat.command       = smm_pkg::CMD_WRITE;
    beat.matrix_select = sel;
    beat.row_index     = row[IDX_W-1:0];
    beat.col_index     = col[IDX_W-1:0];
    beat.element_value = value;
    return beat;
  endfunction

  // Compute beats carry random junk in the fields the block ignores.
  function automatic smm_pkg::in_t compute_beat(int row);
    smm_pkg::in_t beat;
    beat.command       = smm_pkg::CMD_COMPUTE;
    beat.matrix_select = 1'($urandom);
    beat.row_index     = row[IDX_W-1:0];
    beat.col_index     = IDX_W'($urandom);
    beat.element_value = ELEM_W'($urandom);
    return beat;
  endfunction

  // Writes go anywhere; computes only name rows of A that are fully loaded.
  function automatic smm_pkg::in_t random_beat();
    if ($urandom_range(99) < 65) begin
      return write_beat(1'($urandom), $urandom_range(DIM - 1), $urandom_range(DIM - 1),
                        pick_element());
    end
    return compute_beat(pick_loaded_row());
  endfunction

  // Hold off until the block has emitted everything it owes.
  task automatic wait_for_drain();
    while (pending_beats_q.size() != 0 || in_valid || expected_products_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: present the next pending beat, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        apply_matrix_beat(in_data);
      end
      if (!in_valid || in_ready) begin
        if (pending_beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_beats_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and a check on every result beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        check_product_beat(out_data);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus: all of B and four rows of A, fixed rows, then random mixes.
  initial begin
    int send_mix[4];
    int recv_mix[4];
    send_mix = '{0, 73, 0, 24};
    recv_mix = '{0, 0, 73, 24};
    while (!rst_n) @(negedge clk);

    // Row 0 of A and column 0 of B at the negative corner give the largest
    // positive sum; row 0 against column 1 gives the most negative one.
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        pending_beats_q.push_back(write_beat(smm_pkg::SEL_RIGHT, r, c,
          (c == 0) ? 16'sh8000 : (c == 1) ? 16'sh7fff : pick_element()));
        if (r < 3 || r == DIM - 1) begin
          pending_beats_q.push_back(write_beat(smm_pkg::SEL_LEFT, r, c,
            (r == 0) ? 16'sh8000 : (r == 1) ? 16'sh7fff : pick_element()));
        end
      end
    end

    // Fixed rows, overwrites of single corners, and ignored fields all set.
    pending_beats_q.push_back(compute_beat(0));
    pending_beats_q.push_back(compute_beat(1));
    pending_beats_q.push_back(compute_beat(2));
    pending_beats_q.push_back(compute_beat(DIM - 1));
    pending_beats_q.push_back(write_beat(smm_pkg::SEL_LEFT, DIM - 1, DIM - 1, 16'sh8000));
    pending_beats_q.push_back(write_beat(smm_pkg::SEL_RIGHT, DIM - 1, DIM - 1, 16'sh7fff));
    pending_beats_q.push_back(write_beat(smm_pkg::SEL_RIGHT, DIM - 1, 0, 16'sh0000));
    pending_beats_q.push_back(compute_beat(DIM - 1));
    pending_beats_q.push_back(smm_pkg::in_t'{smm_pkg::CMD_COMPUTE, smm_pkg::SEL_RIGHT,
                                             4'd0, 4'hf, 16'shffff});
    pending_beats_q.push_back(smm_pkg::in_t'{smm_pkg::CMD_COMPUTE, smm_pkg::SEL_LEFT,
                                             4'd1, 4'h0, 16'sh0000});
    wait_for_drain();

    // Random traffic under each idling mix, fully drained between mixes.
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = send_mix[m];
      recv_stall_pct = recv_mix[m];
      repeat (BEATS_PER_MIX) pending_beats_q.push_back(random_beat());
      wait_for_drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3 * ROW_LATENCY) @(negedge clk);

    $display("Ran %0d element writes and %0d row computes, %0d result beats checked,",
             write_count, row_count, product_count);
    $display("under no idling, sender gaps, receiver stalls and both together.");
    if (error_count == 0 && expected_products_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results still owed", error_count,
               expected_products_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: square_matrix_multiply.f
+incdir+rtl
rtl/smm_pkg.sv
rtl/smm_ctrl.sv
rtl/smm_dp.sv
rtl/square_matrix_multiply.sv
rtl/smm_checker.sv
tb/tb.sv
